### rtl/spf_pkg.sv
package spf_pkg;

    // Width of the number, the factors and the running remainder.
    localparam int NUM_W = 16;

    // Result counter and the cap on results per query.
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_LAST = 4'd15;

    // Divider step counter: one quotient bit per step.
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_STEP_LAST = 4'd15;

    // Sequencer state codes.
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [ST_W-1:0] ST_FILL    = 4'd1;
    localparam logic [ST_W-1:0] ST_SI_TEST = 4'd2;
    localparam logic [ST_W-1:0] ST_SI_RD   = 4'd3;
    localparam logic [ST_W-1:0] ST_SI_CK   = 4'd4;
    localparam logic [ST_W-1:0] ST_SJ_RD   = 4'd5;
    localparam logic [ST_W-1:0] ST_SJ_CK   = 4'd6;
    localparam logic [ST_W-1:0] ST_START   = 4'd7;
    localparam logic [ST_W-1:0] ST_LK_RD   = 4'd8;
    localparam logic [ST_W-1:0] ST_LK_CK   = 4'd9;
    localparam logic [ST_W-1:0] ST_EMIT    = 4'd10;
    localparam logic [ST_W-1:0] ST_DIV     = 4'd11;

endpackage

### rtl/spf_sieve_prime_factorizer_top.sv
// The first query after reset builds the table: a clearing pass over min(MAX_N, 65536) entries,
// then the sieve, which reads and then checks each visited entry. A normal query passes a start
// state, a table read and a check before it loads its first factor; each further factor follows
// an output load, a restoring divide and a table read. A flagged query loads its one item right
// after the start state. One query at a time: the next is taken in the cycle after the last item
// loads; stalls on m_tready delay it. Reset (rst_n, async, active low) clears the sequencer and
// marks the table unbuilt.
module spf_sieve_prime_factorizer_top
    import spf_pkg::*;
#(
    parameter int MAX_N = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Input stream. s_tdata fields from bit 0: number[15:0].
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [NUM_W-1:0] s_tdata,
    // Result stream. m_tdata fields from bit 0: factor[15:0].
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [NUM_W-1:0] m_tdata,
    // Marks the final factor of the number.
    output logic             m_tlast,
    // m_tuser fields from bit 0: no_factors.
    output logic             m_tuser
);

    // Only indexes below 2^16 can ever be looked up, and the smallest prime factor of such an
    // index depends only on primes below 256, so the table never needs more than 64K entries.
    localparam int TBL_N = (MAX_N < 65536) ? MAX_N : 65536;
    localparam int AW    = $clog2(TBL_N);
    localparam int JW    = AW + 1;
    localparam int IW    = (AW + 1) / 2 + 1;

    // The table memory. An entry of zero means "no smaller factor found", so the index is
    // prime (or below two, which is never looked up). Composite entries hold their smallest
    // prime factor. All sieve accesses are sequenced one at a time, so no read whose data is used
    // overlaps a write to the same entry.
    logic [NUM_W-1:0] tbl_mem [TBL_N];
    logic [NUM_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [NUM_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tbl_mem[mem_raddr];
    end

    logic [ST_W-1:0]      state_reg;
    logic                 tbl_rdy_reg;
    logic                 bad_reg;
    logic [IW-1:0]        i_reg;
    logic [JW-1:0]        j_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     p_reg;
    logic [NUM_W-1:0]     r_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 m_tvalid_reg;
    logic [NUM_W-1:0]     m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;

    logic [2*IW-1:0] i_sq;
    logic            sq_done;
    logic            j_done;
    logic            out_free;
    logic            emit_last;
    logic            in_accept;
    logic            num_bad;
    logic [NUM_W:0]  div_trial;
    logic            div_ge;
    logic [NUM_W:0]  div_diff;

    assign i_sq      = i_reg * i_reg;
    assign sq_done   = 32'(i_sq) >= 32'(TBL_N);
    assign j_done    = 32'(j_reg) >= 32'(TBL_N);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = bad_reg || (p_reg == rem_reg) || (cnt_reg == CNT_LAST);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign num_bad   = (s_tdata < NUM_W'(2)) || (32'(s_tdata) >= 32'(MAX_N));

    // One restoring divide step: shift the next dividend bit in, subtract when it fits.
    assign div_trial = {r_reg, rem_reg[NUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, p_reg};
    assign div_diff  = div_trial - {1'b0, p_reg};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = j_reg[AW-1:0];
        mem_wdata = '0;
        mem_raddr = j_reg[AW-1:0];
        unique case (state_reg)
            ST_FILL:
            begin
                mem_we = 1'b1;
            end
            ST_SI_RD:
            begin
                mem_raddr = AW'(i_reg);
            end
            ST_SJ_CK:
            begin
                mem_we    = (rd_data_reg == '0);
                mem_wdata = NUM_W'(i_reg);
            end
            ST_LK_RD:
            begin
                mem_raddr = rem_reg[AW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tbl_rdy_reg  <= 1'b0;
            bad_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // The output register loads a new item or empties once its item is taken.
            if (state_reg == ST_EMIT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        rem_reg <= s_tdata;
                        bad_reg <= num_bad;
                        cnt_reg <= '0;
                        j_reg   <= '0;
                        state_reg <= tbl_rdy_reg ? ST_START : ST_FILL;
                    end
                end
                ST_FILL:
                begin
                    if (j_reg == JW'(TBL_N - 1))
                    begin
                        i_reg     <= IW'(2);
                        state_reg <= ST_SI_TEST;
                    end
                    j_reg <= j_reg + JW'(1);
                end
                ST_SI_TEST:
                begin
                    if (sq_done)
                    begin
                        tbl_rdy_reg <= 1'b1;
                        state_reg   <= ST_START;
                    end
                    else
                    begin
                        state_reg <= ST_SI_RD;
                    end
                end
                ST_SI_RD:
                begin
                    state_reg <= ST_SI_CK;
                end
                ST_SI_CK:
                begin
                    if (rd_data_reg == '0)
                    begin
                        j_reg     <= JW'(i_sq);
                        state_reg <= ST_SJ_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= ST_SI_TEST;
                    end
                end
                ST_SJ_RD:
                begin
                    if (j_done)
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= ST_SI_TEST;
                    end
                    else
                    begin
                        state_reg <= ST_SJ_CK;
                    end
                end
                ST_SJ_CK:
                begin
                    j_reg     <= j_reg + JW'(i_reg);
                    state_reg <= ST_SJ_RD;
                end
                ST_START:
                begin
                    state_reg <= bad_reg ? ST_EMIT : ST_LK_RD;
                end
                ST_LK_RD:
                begin
                    state_reg <= ST_LK_CK;
                end
                ST_LK_CK:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        if (emit_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            cnt_reg     <= cnt_reg + CNT_W'(1);
                            div_cnt_reg <= '0;
                            state_reg   <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    // The remainder register shifts out dividend bits and takes in quotient bits.
                    rem_reg     <= {rem_reg[NUM_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_STEP_LAST)
                    begin
                        state_reg <= ST_LK_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: divisor, partial remainder of the divider and the output item.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LK_CK)
        begin
            p_reg <= (rd_data_reg == '0) ? rem_reg : rd_data_reg;
        end
        if (state_reg == ST_EMIT)
        begin
            r_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            r_reg <= div_ge ? div_diff[NUM_W-1:0] : div_trial[NUM_W-1:0];
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            m_tdata_reg <= bad_reg ? '0 : p_reg;
            m_tlast_reg <= emit_last;
            m_tuser_reg <= bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // A flagged item is always the only, and so the last, item of its query.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("flagged result is not a single zero item");

    // The table is written only by the clearing pass and the sieve.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_FILL || state_reg == ST_SJ_CK))
        else $error("table written outside the build");

    // The divider never runs with a divisor below two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (p_reg >= NUM_W'(2)))
        else $error("divide started with a bad divisor");

    // Loading the final item of a query returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && emit_last) |=> (state_reg == ST_IDLE))
        else $error("query did not end after its last item");

    // Factor lookups happen only once the table is built.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LK_RD) |-> tbl_rdy_reg)
        else $error("lookup before the table is built");

endmodule

### tb/testbench.sv
`default_nettype none

module testbench
    import spf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Size of the smallest-prime-factor table inside the block.
    localparam int TABLE_DEPTH = 65536;
    // The guard on results per query; a 16-bit number never reaches it.
    localparam int RESULT_CAP = 16;
    // Cycles with no accepted item before the run is declared hung. The first
    // query after reset builds the table, and no item is accepted meanwhile.
    localparam int WATCHDOG_LIMIT = 2_000_000;
    // Cycles to keep watching the result port once nothing is expected.
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 480;
    // The last items of the random part run with no idling on either side.
    localparam int QUIET_TAIL = 80;

    // One expected result item.
    typedef struct packed {
        logic [NUM_W-1:0] factor;
        logic             last;
        logic             no_factors;
    } factor_item_t;

    // Scoreboard: predicts the factors of each accepted number and checks
    // every result item against the oldest prediction still waiting.
    class factor_scoreboard;
        bit [NUM_W-1:0] spf_lut [TABLE_DEPTH];
        bit             lut_built;
        bit [NUM_W-1:0] residue;
        factor_item_t   expected_factors [$];
        int             errors;
        int             queries;
        int             flagged;
        int             checked;
        int             most_factors;

        function new();
            lut_built    = 1'b0;
            residue      = '0;
            errors       = 0;
            queries      = 0;
            flagged      = 0;
            checked      = 0;
            most_factors = 0;
        endfunction

        // Sieve of Eratosthenes: entry i ends up as the smallest prime factor of i.
        function void build_lut();
            int i;
            int j;
            for (i = 0; i < TABLE_DEPTH; i++)
                spf_lut[i] = i[NUM_W-1:0];
            for (i = 2; i * i < TABLE_DEPTH; i++) begin
                if (spf_lut[i] != i[NUM_W-1:0])
                    continue;
                for (j = i * i; j < TABLE_DEPTH; j += i)
                    if (spf_lut[j] == j[NUM_W-1:0])
                        spf_lut[j] = i[NUM_W-1:0];
            end
            lut_built = 1'b1;
        endfunction

        // Called for every number the block accepts.
        function void note_number(bit [NUM_W-1:0] number);
            factor_item_t   item;
            bit [NUM_W-1:0] p;
            int             count;
            if (!lut_built)
                build_lut();
            queries++;
            residue = number;
            if (number < 2 || int'(number) >= TABLE_DEPTH) begin
                // Nothing to factor: a single flagged item.
                item.factor     = '0;
                item.last       = 1'b1;
                item.no_factors = 1'b1;
                expected_factors.push_back(item);
                flagged++;
                return;
            end
            count = 0;
            while (residue > 1 && count < RESULT_CAP) begin
                p = spf_lut[residue];
                if (p < 2)
                    p = residue;
                residue         = residue / p;
                item.factor     = p;
                item.last       = (residue == 1 || count == RESULT_CAP - 1);
                item.no_factors = 1'b0;
                expected_factors.push_back(item);
                count++;
            end
            if (count > most_factors)
                most_factors = count;
        endfunction

        // Called for every result item the block hands over.
        function void check_factor(logic [NUM_W-1:0] factor, logic last, logic no_factors);
            factor_item_t want;
            checked++;
            if (expected_factors.size() == 0) begin
                $error("unexpected result item: factor=%0d last=%0b no_factors=%0b",
                       factor, last, no_factors);
                errors++;
                return;
            end
            want = expected_factors.pop_front();
            if (factor !== want.factor) begin
                $error("factor: expected %0d, actual %0d", want.factor, factor);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            if (no_factors !== want.no_factors) begin
                $error("no_factors: expected %0b, actual %0b", want.no_factors, no_factors);
                errors++;
            end
        endfunction

        function int pending();
            return expected_factors.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [NUM_W-1:0] s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [NUM_W-1:0] m_tdata;
    logic             m_tlast;
    logic             m_tuser;

    factor_scoreboard sb = new();

    // Both sides share quiet and calm: quiet switches idling off for the tail of the
    // run, calm gives stretches without idling in between.
    bit quiet = 1'b0;
    bit calm  = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    spf_sieve_prime_factorizer_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // number[15:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // factor[15:0]
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)    // no_factors
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side backpressure: random stall bursts of random length, driven
    // at the falling edge so the block sees a stable tready at the rising edge.
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 12) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every result item accepted at a rising edge goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_factor(m_tdata, m_tlast, m_tuser);
    end

    // Watchdog on progress: any accepted item on either side resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one number and hold it until the block takes it. Valid is left
    // high so back-to-back items never drop it between them.
    task automatic send_number(input bit [NUM_W-1:0] number);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_number(number);
    endtask

    // Sender gap of a given number of cycles.
    task automatic sender_gap(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom_range(0, 65535);
        end
    endtask

    // Hold the sender off until every predicted factor has come out.
    task automatic wait_drained();
        sender_gap(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Random numbers with a bias toward the interesting shapes: many small
    // factors, prime powers and the flagged values, next to plain uniform ones.
    function automatic bit [NUM_W-1:0] pick_number();
        int primes [6] = '{2, 3, 5, 7, 11, 13};
        int value;
        int p;
        value = 1;
        case ($urandom_range(0, 5))
            0, 1: value = $urandom_range(0, 65535);
            2: value = $urandom_range(0, 15);
            3: begin
                // Product of a random number of small primes, skipping any that would overflow.
                repeat ($urandom_range(1, 16)) begin
                    p = primes[$urandom_range(0, 5)];
                    if (value * p <= 65535)
                        value = value * p;
                end
            end
            4: begin
                // A power of one small prime.
                p = primes[$urandom_range(0, 5)];
                repeat ($urandom_range(1, 16))
                    if (value * p <= 65535)
                        value = value * p;
            end
            default: value = $urandom_range(32768, 65535);
        endcase
        return value[NUM_W-1:0];
    endfunction

    initial
    begin
        // Edge values, both flagged inputs, the largest prime in range, the
        // longest factorization (a power of two), squares of primes and a
        // primorial. Zero and one also follow a normal query, so the block
        // must not reuse a stale remainder.
        static bit [NUM_W-1:0] directed [] = '{
            16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd65535, 16'd65534, 16'd65533,
            16'd65521, 16'd32768, 16'd49152, 16'd65025, 16'd63001, 16'd30030,
            16'd1, 16'd1024, 16'd255, 16'd256, 16'd9, 16'd7919, 16'hAAAA,
            16'h5555, 16'd0, 16'd6
        };
        int k;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The very first query triggers the table build inside the block.
        foreach (directed[n])
            send_number(directed[n]);

        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (k == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            if (k == RANDOM_ITEMS / 2)
                wait_drained();
            if (!quiet && !calm && $urandom_range(0, 3) == 0)
                sender_gap($urandom_range(1, 12));
            send_number(pick_number());
        end
        sender_gap(1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d queries, %0d of them flagged, with %0d result items checked.",
                 sb.queries, sb.flagged, sb.checked);
        $display("The longest factorization had %0d factors.", sb.most_factors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
